### rtl/integer_to_decimal_ascii_defines.svh
// Assertion macros for the datapath of the integer to decimal ASCII converter.
`ifndef INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2DA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/i2da_pkg.sv
// Shared types, constants and the power-of-ten table for the converter.
package i2da_pkg;

  // Conversion modes carried in the func field.
  typedef enum logic [1:0] {
    MODE_S32  = 2'd0,
    MODE_S64  = 2'd1,
    MODE_U32  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;

  // Highest decimal place that a 64-bit or a 32-bit magnitude can reach.
  localparam logic [4:0] TOP_POW_64 = 5'd19;
  localparam logic [4:0] TOP_POW_32 = 5'd9;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CALC,
    ST_DIGIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_sign;
    logic calc_step;
    logic skip;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_ok;
    logic neg_in;
    logic step_last;
    logic digit_zero;
    logic started;
    logic pidx_zero;
    logic out_free;
  } status_t;

  // Power of ten for a decimal place; places beyond the top read as zero.
  function automatic logic [63:0] pow10(input logic [4:0] idx);
    logic [63:0] p;
    unique case (idx)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

### rtl/i2da_if.sv
// Valid/ready channel interfaces for the number input and the text output.
interface i2da_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [63:0] value;

  modport source (output valid, func, value, input ready);
  modport sink (input valid, func, value, output ready);
endinterface

interface i2da_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

### rtl/i2da_ctrl.sv
// Controller state machine that sequences sign, digit trials and emission.
module i2da_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2da_pkg::status_t status,
  output i2da_pkg::cmd_t    cmd
);
  import i2da_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        in_ready = !rst;
        if (!rst && in_valid && status.mode_ok) begin
          cmd.load   = 1'b1;
          state_next = status.neg_in ? ST_SIGN : ST_CALC;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc_step = 1'b1;
        if (status.step_last) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // Leading zeros are dropped, but the units place is always shown.
        if (status.digit_zero && !status.started && !status.pidx_zero) begin
          cmd.skip   = 1'b1;
          state_next = ST_CALC;
        end else if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next     = status.pidx_zero ? ST_IDLE : ST_CALC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/i2da_dp.sv
// Datapath: magnitude register, restoring digit trials and the output register.
`include "integer_to_decimal_ascii_defines.svh"

module i2da_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         func,
  input  logic signed [63:0] value,
  input  i2da_pkg::cmd_t     cmd,
  output i2da_pkg::status_t  status,
  i2da_out_if.source         text
);
  import i2da_pkg::*;

  logic [63:0] mag;
  logic [4:0]  pidx;
  logic [1:0]  step;
  logic [3:0]  digit;
  logic        started;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;

  logic [31:0] low_word;
  logic        neg_in;
  logic [63:0] mag_in;
  logic [63:0] pow;
  logic [67:0] trial;
  logic [67:0] diff;
  logic        fits;
  logic        out_free;
  logic [67:0] pow_x10;

  // Sign and magnitude of the incoming number; negation wraps, so the most
  // negative value yields its exact magnitude.
  always_comb begin
    low_word = value[31:0];
    if (func == MODE_S64) begin
      neg_in = value[63];
      mag_in = value[63] ? (~value + 64'd1) : value;
    end else begin
      neg_in = (func == MODE_S32) && low_word[31];
      mag_in = {32'd0, neg_in ? (~low_word + 32'd1) : low_word};
    end
  end

  // One trial per cycle: 8, 4, 2 and then 1 times the current power of ten.
  assign pow   = pow10(pidx);
  assign trial = {4'd0, pow} << ~step;
  assign diff  = {4'd0, mag} - trial;
  assign fits  = {4'd0, mag} >= trial;

  assign out_free = !out_valid || text.ready;

  // Working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag     <= '0;
      pidx    <= '0;
      step    <= '0;
      digit   <= '0;
      started <= 1'b0;
    end else if (cmd.load) begin
      mag     <= mag_in;
      pidx    <= (func == MODE_S64) ? TOP_POW_64 : TOP_POW_32;
      step    <= 2'd0;
      digit   <= 4'd0;
      started <= 1'b0;
    end else if (cmd.calc_step) begin
      step <= step + 2'd1;
      if (fits) begin
        mag         <= diff[63:0];
        digit[~step] <= 1'b1;
      end
    end else if (cmd.skip || cmd.emit_digit) begin
      digit <= 4'd0;
      if (pidx != 5'd0) begin
        pidx <= pidx - 5'd1;
      end
      if (cmd.emit_digit) begin
        started <= 1'b1;
      end
    end
  end

  // Output register: holds a character until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= CHAR_ZERO + {4'd0, digit};
      out_last <= (pidx == 5'd0);
    end
  end

  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

  // Status toward the controller.
  always_comb begin
    status            = '0;
    status.mode_ok    = (func != MODE_NONE);
    status.neg_in     = neg_in;
    status.step_last  = (step == 2'd3);
    status.digit_zero = (digit == 4'd0);
    status.started    = started;
    status.pidx_zero  = (pidx == 5'd0);
    status.out_free   = out_free;
  end

  // Ten times the current power, for the range check on each new place.
  assign pow_x10 = {1'b0, pow, 3'd0} + {3'd0, pow, 1'b0};

  `I2DA_ASSERT_SAME(a_mag_in_range, clk, rst, cmd.calc_step && (step == 2'd0),
    {4'd0, mag} < pow_x10, "magnitude exceeds ten times the current place")
  `I2DA_ASSERT_NEXT(a_digit_range, clk, rst, cmd.calc_step && (step == 2'd3),
    digit <= DIGIT_MAX, "digit trials produced a value above nine")
  `I2DA_ASSERT_SAME(a_emit_free, clk, rst, cmd.emit_sign || cmd.emit_digit,
    out_free, "character issued while the output register is still full")
  `I2DA_ASSERT_SAME(a_last_is_digit, clk, rst, out_valid && out_last,
    (out_char >= CHAR_ZERO) && (out_char <= CHAR_ZERO + 8'd9),
    "final character of a number is not a digit")

endmodule

### rtl/integer_to_decimal_ascii.sv
// Top level of the integer to decimal ASCII converter.
// Each beat on num carries a value and a mode (signed 32-bit, signed 64-bit or
// unsigned 32-bit; mode 3 is taken and dropped), and the block answers with the
// decimal text on text, one ASCII character per beat, a leading '-' for
// negative values, no leading zeros, a single '0' for zero, and last set on
// the final digit. One number is converted at a time. Every decimal place
// takes four restoring trials through a single 68-bit compare-subtract,
// after which its digit is emitted or dropped, and the scan starts at the
// tenth place in 32-bit modes and the twentieth in 64-bit mode. The next
// number is accepted as soon as the last character sits in the output register.
module integer_to_decimal_ascii (
  input logic        clk,
  input logic        rst,
  i2da_in_if.sink    num,
  i2da_out_if.source text
);
  import i2da_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign num.ready = in_ready;

  // Sequencer.
  i2da_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (num.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and output register.
  i2da_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .func   (num.func),
    .value  (num.value),
    .cmd    (cmd),
    .status (status),
    .text   (text)
  );

endmodule
